// ===== sv/qau_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qau_pkg
// Shared types, widths, op codes and saturation for the quaternion unit.
// ----------------------------------------------------------------------------
package qau_pkg;

    localparam int COMP_W = 32;
    localparam int FRAC_W = 16;
    localparam int LANES  = 4;
    localparam int OP_W   = 3;

    localparam int PROD_W     = 2 * COMP_W;
    localparam int SUM_W      = PROD_W + 2;
    localparam int SQ_W       = PROD_W + 1;
    localparam int ROOT_W     = (SQ_W + 1) / 2;
    localparam int SQRT_STEPS = ROOT_W;
    localparam int NUM_W      = 2 * COMP_W;
    localparam int DIV_STEPS  = NUM_W;
    localparam int SAT_W      = SQ_W + 2;
    localparam int TRIAL_W    = SQ_W + 2;

    // pipeline stage numbers, input register is stage 0
    localparam int ST_EARLY = 3;
    localparam int ST_LEN   = ST_EARLY + SQRT_STEPS;
    localparam int ST_SETUP = ST_LEN + 1;
    localparam int ST_LAST  = ST_SETUP + DIV_STEPS + 1;

    localparam logic [OP_W-1:0] OP_MUL   = 3'd0;
    localparam logic [OP_W-1:0] OP_NORM  = 3'd1;
    localparam logic [OP_W-1:0] OP_INV   = 3'd2;
    localparam logic [OP_W-1:0] OP_SCALE = 3'd3;
    localparam logic [OP_W-1:0] OP_SQLEN = 3'd4;
    localparam logic [OP_W-1:0] OP_LEN   = 3'd5;

    typedef logic signed [COMP_W-1:0] comp_t;
    typedef comp_t [LANES-1:0] quat_t;
    typedef logic signed [PROD_W-1:0] prod_t;
    typedef prod_t [LANES-1:0] prods_t;

    typedef struct packed {
        logic  ovf;
        comp_t val;
    } lane_res_t;

    typedef lane_res_t [LANES-1:0] qres_t;

    typedef struct packed {
        logic [ROOT_W-1:0] len;
        logic [SQ_W-1:0]   s;
        logic              zero;
        lane_res_t         sq;
    } merge_t;

    // product terms subtracted in each lane of the hamilton product
    localparam logic [LANES-1:0] MUL_NEG [LANES] = '{4'b1110, 4'b1000, 4'b0010, 4'b0100};

    localparam comp_t COMP_MAX = {1'b0, {(COMP_W-1){1'b1}}};
    localparam comp_t COMP_MIN = {1'b1, {(COMP_W-1){1'b0}}};

    localparam logic signed [SAT_W-1:0] SAT_HI =
        {{(SAT_W-COMP_W+1){1'b0}}, {(COMP_W-1){1'b1}}};
    localparam logic signed [SAT_W-1:0] SAT_LO =
        {{(SAT_W-COMP_W+1){1'b1}}, {(COMP_W-1){1'b0}}};

    function automatic lane_res_t sat_val(input logic signed [SAT_W-1:0] v);
        lane_res_t r;
        if (v > SAT_HI)
        begin
            r.ovf = 1'b1;
            r.val = COMP_MAX;
        end
        else if (v < SAT_LO)
        begin
            r.ovf = 1'b1;
            r.val = COMP_MIN;
        end
        else
        begin
            r.ovf = 1'b0;
            r.val = v[COMP_W-1:0];
        end
        return r;
    endfunction

endpackage

// ===== sv/qau_lane.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qau_lane
// One component lane: four multipliers, signed lane sum, round and saturate.
// ----------------------------------------------------------------------------
module qau_lane
    import qau_pkg::*;
#(
    parameter int LANE = 0
)
(
    input  logic            clk,
    input  logic            en,
    input  logic [OP_W-1:0] op0,
    input  logic [OP_W-1:0] op1,
    input  quat_t           a,
    input  quat_t           b,
    input  comp_t           f,
    output prod_t           sq,
    output lane_res_t       res
);

    localparam logic signed [SUM_W-1:0] RND =
        {{(SUM_W-FRAC_W){1'b0}}, 1'b1, {(FRAC_W-1){1'b0}}};

    comp_t                    x [LANES];
    comp_t                    y [LANES];
    prod_t                    prod_next [LANES];
    prod_t                    prod_reg [LANES];
    logic signed [SUM_W-1:0]  sum_next;
    logic signed [SUM_W-1:0]  sum_reg;
    logic signed [SUM_W-1:0]  rs;
    lane_res_t                res_next;
    lane_res_t                res_reg;

    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            if (op0 == OP_MUL)
            begin
                x[i] = a[i];
                y[i] = b[2'(LANE ^ i)];
            end
            else if (i == 0)
            begin
                x[i] = a[LANE];
                y[i] = (op0 == OP_SCALE) ? f : a[LANE];
            end
            else
            begin
                x[i] = '0;
                y[i] = '0;
            end
            prod_next[i] = x[i] * y[i];
        end
    end

    always_comb
    begin
        sum_next = SUM_W'(prod_reg[0]);
        if (op1 == OP_MUL)
        begin
            sum_next = '0;
            for (int i = 0; i < LANES; i++)
            begin
                if (MUL_NEG[LANE][i])
                    sum_next = sum_next - SUM_W'(prod_reg[i]);
                else
                    sum_next = sum_next + SUM_W'(prod_reg[i]);
            end
        end
    end

    always_comb
    begin
        rs       = (sum_reg + RND) >>> FRAC_W;
        res_next = sat_val(SAT_W'(rs));
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= prod_next;
            sum_reg  <= sum_next;
            res_reg  <= res_next;
        end
    end

    assign sq  = prod_reg[0];
    assign res = res_reg;

endmodule

// ===== sv/qau_merge.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qau_merge
// Sums the lane squares and takes the rounded square root, one bit per stage.
// ----------------------------------------------------------------------------
module qau_merge
    import qau_pkg::*;
(
    input  logic   clk,
    input  logic   en,
    input  prods_t sq,
    output merge_t m
);

    localparam logic [SQ_W:0] HALF = {{(SQ_W+1-FRAC_W){1'b0}}, 1'b1, {(FRAC_W-1){1'b0}}};

    logic [SQ_W-1:0]   s_next;
    logic [SQ_W-1:0]   s_reg;
    logic [ROOT_W-1:0] q_next [SQRT_STEPS];
    logic [ROOT_W-1:0] q_reg  [SQRT_STEPS];
    logic [SQ_W-1:0]   r_next [SQRT_STEPS];
    logic [SQ_W-1:0]   r_reg  [SQRT_STEPS];
    logic [SQ_W-1:0]   s_dly  [SQRT_STEPS+1];
    logic              z_dly  [SQRT_STEPS+1];
    lane_res_t         sq_dly [SQRT_STEPS+1];
    logic [SQ_W:0]     sq_rnd;
    lane_res_t         sq_next;
    logic [ROOT_W-1:0] len_next;
    logic [ROOT_W-1:0] len_reg;

    always_comb
    begin
        s_next = '0;
        for (int i = 0; i < LANES; i++)
            s_next = s_next + {1'b0, sq[i]};
    end

    always_comb
    begin
        sq_rnd  = ({1'b0, s_reg} + HALF) >> FRAC_W;
        sq_next = sat_val($signed({1'b0, sq_rnd}));
    end

    // restoring root: keep root q and remainder n - q*q
    always_comb
    begin
        int                k;
        logic [ROOT_W-1:0] q_in;
        logic [SQ_W-1:0]   r_in;
        logic [TRIAL_W-1:0] trial;
        for (int j = 0; j < SQRT_STEPS; j++)
        begin
            k     = SQRT_STEPS - 1 - j;
            q_in  = (j == 0) ? '0 : q_reg[j-1];
            r_in  = (j == 0) ? s_reg : r_reg[j-1];
            trial = (TRIAL_W'(q_in) << (k + 1)) + (TRIAL_W'(1) << (2 * k));
            if (TRIAL_W'(r_in) >= trial)
            begin
                r_next[j] = r_in - trial[SQ_W-1:0];
                q_next[j] = q_in | (ROOT_W'(1) << k);
            end
            else
            begin
                r_next[j] = r_in;
                q_next[j] = q_in;
            end
        end
    end

    assign len_next = q_reg[SQRT_STEPS-1]
                    + ROOT_W'(r_reg[SQRT_STEPS-1] > SQ_W'(q_reg[SQRT_STEPS-1]));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s_reg     <= s_next;
            q_reg     <= q_next;
            r_reg     <= r_next;
            s_dly[0]  <= s_reg;
            z_dly[0]  <= (s_reg == '0);
            sq_dly[0] <= sq_next;
            for (int n = 1; n <= SQRT_STEPS; n++)
            begin
                s_dly[n]  <= s_dly[n-1];
                z_dly[n]  <= z_dly[n-1];
                sq_dly[n] <= sq_dly[n-1];
            end
            len_reg <= len_next;
        end
    end

    assign m.len  = len_reg;
    assign m.s    = s_dly[SQRT_STEPS];
    assign m.zero = z_dly[SQRT_STEPS];
    assign m.sq   = sq_dly[SQRT_STEPS];

endmodule

// ===== sv/qau_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qau_div
// Pipelined restoring divider, one quotient bit per stage, round to nearest.
// ----------------------------------------------------------------------------
module qau_div
    import qau_pkg::*;
(
    input  logic             clk,
    input  logic             en,
    input  logic [NUM_W-1:0] num,
    input  logic [SQ_W-1:0]  den,
    input  logic             neg,
    output logic [NUM_W:0]   q,
    output logic             q_neg
);

    logic [NUM_W-1:0] nq0_reg;
    logic [SQ_W-1:0]  d0_reg;
    logic             neg0_reg;
    logic [NUM_W-1:0] nq_next  [DIV_STEPS];
    logic [NUM_W-1:0] nq_reg   [DIV_STEPS];
    logic [SQ_W-1:0]  r_next   [DIV_STEPS];
    logic [SQ_W-1:0]  r_reg    [DIV_STEPS];
    logic [SQ_W-1:0]  d_reg    [DIV_STEPS];
    logic             neg_reg  [DIV_STEPS];
    logic [NUM_W:0]   q_next;
    logic [NUM_W:0]   q_reg;
    logic             qneg_reg;

    // numerator bits shift out the top while quotient bits shift in below
    always_comb
    begin
        logic [NUM_W-1:0] nq_in;
        logic [SQ_W-1:0]  r_in;
        logic [SQ_W-1:0]  d_in;
        logic [SQ_W:0]    rs;
        for (int j = 0; j < DIV_STEPS; j++)
        begin
            nq_in = (j == 0) ? nq0_reg : nq_reg[j-1];
            r_in  = (j == 0) ? '0 : r_reg[j-1];
            d_in  = (j == 0) ? d0_reg : d_reg[j-1];
            rs    = {r_in, nq_in[NUM_W-1]};
            if (rs >= {1'b0, d_in})
            begin
                r_next[j]  = SQ_W'(rs - {1'b0, d_in});
                nq_next[j] = {nq_in[NUM_W-2:0], 1'b1};
            end
            else
            begin
                r_next[j]  = SQ_W'(rs);
                nq_next[j] = {nq_in[NUM_W-2:0], 1'b0};
            end
        end
    end

    assign q_next = {1'b0, nq_reg[DIV_STEPS-1]}
                  + (NUM_W+1)'({r_reg[DIV_STEPS-1], 1'b0} >= {1'b0, d_reg[DIV_STEPS-1]});

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            nq0_reg    <= num;
            d0_reg     <= den;
            neg0_reg   <= neg;
            nq_reg     <= nq_next;
            r_reg      <= r_next;
            d_reg[0]   <= d0_reg;
            neg_reg[0] <= neg0_reg;
            for (int j = 1; j < DIV_STEPS; j++)
            begin
                d_reg[j]   <= d_reg[j-1];
                neg_reg[j] <= neg_reg[j-1];
            end
            q_reg    <= q_next;
            qneg_reg <= neg_reg[DIV_STEPS-1];
        end
    end

    assign q     = q_reg;
    assign q_neg = qneg_reg;

endmodule

// ===== sv/quaternion_arith_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quaternion_arith_unit
// Q16.16 quaternion product, normalize, inverse, scale, squared length, length.
// ----------------------------------------------------------------------------
// Fully pipelined: one word is accepted every cycle while in_stall is low,
// and every op passes through the same pipeline stages. The depth is set by
// the 33-stage square root on the summed squares followed by the 64-stage
// per-lane divider; four component lanes run side by side. A skid register
// behind the output register lets the input keep flowing for one more word
// when the output is stalled. Results saturate with overflow set; normalize
// or inverse of the zero quaternion returns zeros with zero_length set.
// ----------------------------------------------------------------------------
module quaternion_arith_unit
    import qau_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [2:0]         op,
    input  logic signed [31:0] a_w,
    input  logic signed [31:0] a_x,
    input  logic signed [31:0] a_y,
    input  logic signed [31:0] a_z,
    input  logic signed [31:0] b_w,
    input  logic signed [31:0] b_x,
    input  logic signed [31:0] b_y,
    input  logic signed [31:0] b_z,
    input  logic signed [31:0] factor,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] r_w,
    output logic signed [31:0] r_x,
    output logic signed [31:0] r_y,
    output logic signed [31:0] r_z,
    output logic               overflow,
    output logic               zero_length
);

    localparam int PASS_N  = ST_LAST - ST_SETUP + 1;
    localparam int EARLY_N = ST_LEN - ST_EARLY;

    logic            en;
    logic            vld_reg  [ST_LAST+1];
    logic [OP_W-1:0] op_reg   [ST_LAST+1];
    quat_t           a_reg    [ST_LEN+1];
    quat_t           b_reg;
    comp_t           f_reg;
    qres_t           e_lane;
    qres_t           e_reg    [EARLY_N];
    prods_t          sq_w;
    merge_t          mrg;
    qres_t           pass_next;
    qres_t           pass_reg [PASS_N];
    logic            zl_next;
    logic            zl_reg   [PASS_N];
    logic [NUM_W-1:0] num     [LANES];
    logic [SQ_W-1:0] den;
    logic            dneg     [LANES];
    logic [NUM_W:0]  dq       [LANES];
    logic            dqneg    [LANES];
    lane_res_t       len_sat;
    qres_t           p_res;
    logic            p_zl;
    logic            take;
    logic            out_vld_reg;
    qres_t           out_res_reg;
    logic            out_zl_reg;
    logic            skid_vld_reg;
    qres_t           skid_res_reg;
    logic            skid_zl_reg;

    assign en       = ~skid_vld_reg;
    assign in_stall = skid_vld_reg;
    assign take     = out_vld_reg & ~out_stall;

    for (genvar k = 0; k < LANES; k++)
    begin : g_lane
        qau_lane #(.LANE(k)) u_lane
        (
            .clk (clk),
            .en  (en),
            .op0 (op_reg[0]),
            .op1 (op_reg[1]),
            .a   (a_reg[0]),
            .b   (b_reg),
            .f   (f_reg),
            .sq  (sq_w[k]),
            .res (e_lane[k])
        );

        qau_div u_div
        (
            .clk   (clk),
            .en    (en),
            .num   (num[k]),
            .den   (den),
            .neg   (dneg[k]),
            .q     (dq[k]),
            .q_neg (dqneg[k])
        );
    end

    qau_merge u_merge
    (
        .clk (clk),
        .en  (en),
        .sq  (sq_w),
        .m   (mrg)
    );

    // divider operands and pass-through results
    always_comb
    begin
        comp_t            a_k;
        logic [COMP_W-1:0] mag;
        logic             inv;
        inv     = (op_reg[ST_LEN] == OP_INV);
        len_sat = sat_val({{(SAT_W-ROOT_W){1'b0}}, mrg.len});
        den     = inv ? mrg.s : SQ_W'(mrg.len);
        zl_next = mrg.zero && (op_reg[ST_LEN] == OP_NORM || op_reg[ST_LEN] == OP_INV);
        for (int k = 0; k < LANES; k++)
        begin
            a_k = a_reg[ST_LEN][k];
            mag = a_k[COMP_W-1] ? COMP_W'(-a_k) : a_k;
            if (inv && k != 0)
                dneg[k] = (a_k > 0);
            else
                dneg[k] = a_k[COMP_W-1];
            num[k] = inv ? (NUM_W'(mag) << (2 * FRAC_W)) : (NUM_W'(mag) << FRAC_W);
            unique case (op_reg[ST_LEN])
                OP_MUL, OP_SCALE: pass_next[k] = e_reg[EARLY_N-1][k];
                OP_SQLEN:         pass_next[k] = (k == 0) ? mrg.sq : '0;
                OP_LEN:           pass_next[k] = (k == 0) ? len_sat : '0;
                default:          pass_next[k] = '0;
            endcase
        end
    end

    always_comb
    begin
        logic signed [SAT_W-1:0] qs;
        logic [OP_W-1:0]         op_l;
        op_l = op_reg[ST_LAST];
        p_zl = zl_reg[PASS_N-1];
        for (int k = 0; k < LANES; k++)
        begin
            qs = $signed({{(SAT_W-NUM_W-1){1'b0}}, dq[k]});
            if (dqneg[k])
                qs = -qs;
            if (op_l == OP_NORM || op_l == OP_INV)
                p_res[k] = p_zl ? '0 : sat_val(qs);
            else
                p_res[k] = pass_reg[PASS_N-1][k];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_reg[0]  <= {a_z, a_y, a_x, a_w};
            b_reg     <= {b_z, b_y, b_x, b_w};
            f_reg     <= factor;
            op_reg[0] <= op;
            for (int n = 1; n <= ST_LAST; n++)
                op_reg[n] <= op_reg[n-1];
            for (int n = 1; n <= ST_LEN; n++)
                a_reg[n] <= a_reg[n-1];
            e_reg[0] <= e_lane;
            for (int n = 1; n < EARLY_N; n++)
                e_reg[n] <= e_reg[n-1];
            pass_reg[0] <= pass_next;
            zl_reg[0]   <= zl_next;
            for (int n = 1; n < PASS_N; n++)
            begin
                pass_reg[n] <= pass_reg[n-1];
                zl_reg[n]   <= zl_reg[n-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int n = 0; n <= ST_LAST; n++)
                vld_reg[n] <= 1'b0;
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end
        else
        begin
            if (en)
            begin
                vld_reg[0] <= in_valid;
                for (int n = 1; n <= ST_LAST; n++)
                    vld_reg[n] <= vld_reg[n-1];
            end
            if (!out_vld_reg || take)
            begin
                if (skid_vld_reg)
                begin
                    out_vld_reg  <= 1'b1;
                    skid_vld_reg <= 1'b0;
                end
                else
                    out_vld_reg <= vld_reg[ST_LAST];
            end
            else if (vld_reg[ST_LAST] && en)
                skid_vld_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_vld_reg || take)
        begin
            if (skid_vld_reg)
            begin
                out_res_reg <= skid_res_reg;
                out_zl_reg  <= skid_zl_reg;
            end
            else
            begin
                out_res_reg <= p_res;
                out_zl_reg  <= p_zl;
            end
        end
        else if (vld_reg[ST_LAST] && en)
        begin
            skid_res_reg <= p_res;
            skid_zl_reg  <= p_zl;
        end
    end

    assign out_valid   = out_vld_reg;
    assign r_w         = out_res_reg[0].val;
    assign r_x         = out_res_reg[1].val;
    assign r_y         = out_res_reg[2].val;
    assign r_z         = out_res_reg[3].val;
    assign zero_length = out_zl_reg;

    always_comb
    begin
        overflow = 1'b0;
        for (int k = 0; k < LANES; k++)
            overflow = overflow | out_res_reg[k].ovf;
    end

    // skid word only exists behind a held output word
    assert property (@(posedge clk) disable iff (!rst_n) in_stall |-> out_valid)
        else $error("skid full without output word");

    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(in_stall) |-> $past(out_valid && out_stall))
        else $error("skid filled while output was free");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && zero_length |->
            !overflow && r_w == 0 && r_x == 0 && r_y == 0 && r_z == 0)
        else $error("zero length word carries data");

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the Q16.16 quaternion arithmetic unit.
// ----------------------------------------------------------------------------
// A queue of words (directed corner cases, then random ones) feeds a clocked
// driver. Every accepted word is run through an exact wide-integer model of
// the product, normalize, inverse, scale and length math, and the expected
// result is queued. A clocked monitor compares each output word field by
// field. Both sides idle at random, apart from one stretch in which neither
// idles, and one long output hold-off backs the pipeline up into its input.
// ----------------------------------------------------------------------------
module tb_top;
    import qau_pkg::*;

    localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN_CYCLES   = 150;
    localparam int RANDOM_WORDS   = 600;

    typedef logic signed [127:0] wide_t;

    typedef struct packed {
        logic [OP_W-1:0] op;
        quat_t           a;
        quat_t           b;
        comp_t           factor;
    } qword_t;

    typedef struct packed {
        quat_t r;
        logic  overflow;
        logic  zero_length;
    } qresult_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [2:0]         op = '0;
    logic signed [31:0] a_w = '0, a_x = '0, a_y = '0, a_z = '0;
    logic signed [31:0] b_w = '0, b_x = '0, b_y = '0, b_z = '0;
    logic signed [31:0] factor = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic signed [31:0] r_w, r_x, r_y, r_z;
    logic               overflow;
    logic               zero_length;

    qword_t   pending_words[$];
    qresult_t expected_results[$];
    int       errors = 0;
    int       cyc = 0;
    int       quiet_cnt = 0;
    int       hold_cnt = 0;
    bit       hold_done = 1'b0;

    quaternion_arith_unit u_top (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .op(op),
        .a_w(a_w), .a_x(a_x), .a_y(a_y), .a_z(a_z),
        .b_w(b_w), .b_x(b_x), .b_y(b_y), .b_z(b_z), .factor(factor),
        .out_valid(out_valid), .out_stall(out_stall),
        .r_w(r_w), .r_x(r_x), .r_y(r_y), .r_z(r_z),
        .overflow(overflow), .zero_length(zero_length)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    function automatic wide_t round_frac(input wide_t v);
        return (v + (wide_t'(1) <<< (FRAC_W - 1))) >>> FRAC_W;
    endfunction

    function automatic wide_t div_nearest(input wide_t num, input wide_t den);
        logic [127:0] mag;
        logic [127:0] q;
        logic [127:0] rem;
        mag = (num < 0) ? -num : num;
        q   = mag / den;
        rem = mag % den;
        if ((rem << 1) >= den)
            q = q + 1;
        return (num < 0) ? -wide_t'(q) : wide_t'(q);
    endfunction

    function automatic wide_t root_nearest(input wide_t n);
        logic [127:0] res;
        logic [127:0] t;
        res = '0;
        for (int i = 35; i >= 0; i--)
        begin
            t = res | (128'd1 << i);
            if (t * t <= n)
                res = t;
        end
        if (n - res * res > res)
            res = res + 1;
        return wide_t'(res);
    endfunction

    function automatic comp_t clamp_comp(input wide_t v, inout logic ovf);
        if (v > wide_t'(COMP_MAX))
        begin
            ovf = 1'b1;
            return COMP_MAX;
        end
        if (v < wide_t'(COMP_MIN))
        begin
            ovf = 1'b1;
            return COMP_MIN;
        end
        return comp_t'(v);
    endfunction

    function automatic qresult_t quat_predict(input qword_t w);
        wide_t    a[4];
        wide_t    b[4];
        wide_t    r[4];
        wide_t    f;
        wide_t    sq;
        wide_t    len;
        int       nres;
        qresult_t res;
        for (int i = 0; i < 4; i++)
        begin
            a[i] = w.a[i];
            b[i] = w.b[i];
            r[i] = '0;
        end
        f = w.factor;
        sq = a[0]*a[0] + a[1]*a[1] + a[2]*a[2] + a[3]*a[3];
        nres = 0;
        res = '0;
        case (w.op)
            OP_MUL:
            begin
                r[0] = round_frac(a[0]*b[0] - a[1]*b[1] - a[2]*b[2] - a[3]*b[3]);
                r[1] = round_frac(a[0]*b[1] + a[1]*b[0] + a[2]*b[3] - a[3]*b[2]);
                r[2] = round_frac(a[0]*b[2] - a[1]*b[3] + a[2]*b[0] + a[3]*b[1]);
                r[3] = round_frac(a[0]*b[3] + a[1]*b[2] - a[2]*b[1] + a[3]*b[0]);
                nres = 4;
            end
            OP_NORM, OP_INV:
            begin
                if (sq == 0)
                    res.zero_length = 1'b1;
                else
                begin
                    len = root_nearest(sq);
                    for (int i = 0; i < 4; i++)
                    begin
                        if (w.op == OP_NORM)
                            r[i] = div_nearest(a[i] <<< FRAC_W, len);
                        else
                            r[i] = div_nearest((i == 0 ? a[i] : -a[i]) <<< (2 * FRAC_W), sq);
                    end
                    nres = 4;
                end
            end
            OP_SCALE:
            begin
                for (int i = 0; i < 4; i++)
                    r[i] = round_frac(a[i] * f);
                nres = 4;
            end
            OP_SQLEN:
            begin
                r[0] = round_frac(sq);
                nres = 1;
            end
            OP_LEN:
            begin
                r[0] = root_nearest(sq);
                nres = 1;
            end
            default:
                nres = 0;
        endcase
        for (int i = 0; i < nres; i++)
            res.r[i] = clamp_comp(r[i], res.overflow);
        return res;
    endfunction

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] exp_val);
        $display("mismatch at %0t: %s got %h expected %h", $time, field, got, exp_val);
        errors++;
    endtask

    function automatic comp_t rand_comp();
        case ($urandom_range(0, 5))
            0, 1: return comp_t'($urandom);
            2, 3: return comp_t'($urandom_range(0, 32'h7ffff)) - comp_t'(32'h40000);
            4:    return comp_t'($urandom_range(0, 16)) - comp_t'(8);
            default:
            begin
                case ($urandom_range(0, 3))
                    0: return COMP_MAX;
                    1: return COMP_MIN;
                    2: return '0;
                    default: return comp_t'(32'h10000);
                endcase
            end
        endcase
    endfunction

    function automatic qword_t make_word(input logic [OP_W-1:0] o, input comp_t w0,
                                         input comp_t w1, input comp_t w2,
                                         input comp_t w3, input comp_t fv);
        qword_t w;
        w.op = o;
        w.a = {w3, w2, w1, w0};
        w.b = {w0, w3, w2, w1};
        w.factor = fv;
        return w;
    endfunction

    // driver
    always @(posedge clk)
    begin
        qword_t w;
        cyc <= cyc + 1;
        if (in_valid && !in_stall)
            expected_results.push_back(quat_predict({op, {a_z, a_y, a_x, a_w},
                                                     {b_z, b_y, b_x, b_w}, factor}));
        if (!in_valid || !in_stall)
        begin
            if (rst_n && pending_words.size() != 0 &&
                ((cyc >= 600 && cyc < 900) || $urandom_range(0, 99) >= 28))
            begin
                w = pending_words.pop_front();
                op <= w.op;
                a_w <= w.a[0];
                a_x <= w.a[1];
                a_y <= w.a[2];
                a_z <= w.a[3];
                b_w <= w.b[0];
                b_x <= w.b[1];
                b_y <= w.b[2];
                b_z <= w.b[3];
                factor <= w.factor;
                in_valid <= 1'b1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // monitor
    always @(posedge clk)
    begin
        qresult_t e;
        if (out_valid && !out_stall)
        begin
            if (expected_results.size() == 0)
            begin
                $display("unexpected output word at %0t", $time);
                errors++;
            end
            else
            begin
                e = expected_results.pop_front();
                if (r_w !== e.r[0]) report_mismatch("r_w", r_w, e.r[0]);
                if (r_x !== e.r[1]) report_mismatch("r_x", r_x, e.r[1]);
                if (r_y !== e.r[2]) report_mismatch("r_y", r_y, e.r[2]);
                if (r_z !== e.r[3]) report_mismatch("r_z", r_z, e.r[3]);
                if (overflow !== e.overflow)
                    report_mismatch("overflow", 32'(overflow), 32'(e.overflow));
                if (zero_length !== e.zero_length)
                    report_mismatch("zero_length", 32'(zero_length), 32'(e.zero_length));
            end
        end
        // long hold-off once the pipe has words in flight
        if (!hold_done && expected_results.size() > 20)
        begin
            hold_cnt <= hold_cnt + 1;
            if (hold_cnt >= 400)
                hold_done <= 1'b1;
            out_stall <= 1'b1;
        end
        else if (cyc >= 600 && cyc < 900)
            out_stall <= 1'b0;
        else
            out_stall <= ($urandom_range(0, 99) < 28);
    end

    // watchdog
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n)
            quiet_cnt <= 0;
        else
            quiet_cnt <= quiet_cnt + 1;
        if (quiet_cnt >= WATCHDOG_LIMIT)
        begin
            $display("** quaternion_arith_unit: FAILED **");
            $finish;
        end
    end

    initial
    begin
        logic [OP_W-1:0] o;
        comp_t one;
        one = comp_t'(32'h10000);
        for (int i = 0; i <= 7; i++)
        begin
            o = OP_W'(i);
            pending_words.push_back(make_word(o, one, comp_t'(32'h8000),
                                              -comp_t'(32'h20000), comp_t'(3), one));
        end
        pending_words.push_back(make_word(OP_NORM, '0, '0, '0, '0, '0));
        pending_words.push_back(make_word(OP_INV, '0, '0, '0, '0, '0));
        pending_words.push_back(make_word(OP_INV, comp_t'(1), '0, '0, '0, '0));
        pending_words.push_back(make_word(OP_NORM, '0, '0, comp_t'(1), '0, '0));
        pending_words.push_back(make_word(OP_MUL, COMP_MAX, COMP_MAX, COMP_MAX, COMP_MAX,
                                          COMP_MIN));
        pending_words.push_back(make_word(OP_MUL, COMP_MIN, COMP_MIN, COMP_MIN, COMP_MIN,
                                          COMP_MAX));
        pending_words.push_back(make_word(OP_SCALE, COMP_MIN, COMP_MAX, -one, one, COMP_MIN));
        pending_words.push_back(make_word(OP_SCALE, COMP_MAX, '0, one, -one, COMP_MAX));
        pending_words.push_back(make_word(OP_SQLEN, COMP_MIN, COMP_MIN, COMP_MIN, COMP_MIN,
                                          '0));
        pending_words.push_back(make_word(OP_LEN, COMP_MIN, COMP_MIN, COMP_MIN, COMP_MIN,
                                          '0));
        pending_words.push_back(make_word(OP_NORM, COMP_MAX, COMP_MIN, COMP_MAX, COMP_MIN,
                                          '0));
        pending_words.push_back(make_word(OP_INV, COMP_MAX, COMP_MIN, '0, comp_t'(-1), '0));
        pending_words.push_back(make_word(OP_LEN, comp_t'(-1), comp_t'(-1), '0, '0,
                                          comp_t'(-1)));
        pending_words.push_back(make_word(OP_SPARE_HI, COMP_MAX, COMP_MIN, one, one, one));
        pending_words.push_back(make_word(OP_SPARE_LO, comp_t'(-1), comp_t'(-1), comp_t'(-1),
                                          comp_t'(-1), comp_t'(-1)));
        for (int n = 0; n < RANDOM_WORDS; n++)
        begin
            qword_t w;
            w.op = (n % 40 == 0) ? OP_W'($urandom_range(OP_SPARE_LO, OP_SPARE_HI))
                                 : OP_W'($urandom_range(OP_MUL, OP_LEN));
            for (int i = 0; i < 4; i++)
            begin
                w.a[i] = rand_comp();
                w.b[i] = rand_comp();
            end
            w.factor = rand_comp();
            pending_words.push_back(w);
        end

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_words.size() != 0 || in_valid || expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("** quaternion_arith_unit: PASSED **");
        else
            $display("** quaternion_arith_unit: FAILED **");
        $finish;
    end

endmodule
